### rtl/dil_pkg.sv
// ----------------------------------------------------------------------------
// dil_pkg : shared types and constants for the die id lfsr id generator
// Control word layout, datapath control and hash constants.
// ----------------------------------------------------------------------------
package dil_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned LFSR_W = 64;
	localparam int unsigned BIT_W = $clog2(WORD_W);

	localparam logic [LFSR_W-1:0] LFSR_TAPS = 64'hD800_0000_0000_0000;

	// fixed low bytes of a generated mac: 0x11, 0x1a, 0x00
	localparam logic [23:0] MAC_TAIL = 24'h11_1A_00;
	localparam int unsigned MAC_RAND_W = 24;

	localparam int unsigned BLEND_ROUNDS = 32;
	localparam int unsigned ROUND_W = $clog2(BLEND_ROUNDS + 1);
	localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(BLEND_ROUNDS - 1);

	localparam logic ACT_MAC = 1'b0;
	localparam logic ACT_ID64 = 1'b1;

	localparam logic [1:0] REG_DIE_WORD0 = 2'd0;
	localparam logic [1:0] REG_DIE_WORD1 = 2'd1;
	localparam logic [1:0] REG_DIE_WORD2 = 2'd2;
	localparam logic [1:0] REG_DIE_WORD3 = 2'd3;

	localparam int unsigned PC_W = 4;
	typedef logic [PC_W-1:0] pc_t;

	// program steps
	localparam pc_t ST_IDLE = 4'd0;
	localparam pc_t ST_LOAD = 4'd1;
	localparam pc_t ST_DIE2 = 4'd2;
	localparam pc_t ST_DIE3 = 4'd3;
	localparam pc_t ST_SALT = 4'd4;
	localparam pc_t ST_BLEND = 4'd5;
	localparam pc_t ST_OUT0 = 4'd6;
	localparam pc_t ST_OUT1 = 4'd7;
	localparam pc_t ST_EMIT = 4'd8;

	typedef enum logic [1:0] {
		OP_IDLE,
		OP_LOAD,
		OP_MIX,
		OP_EMIT
	} op_t;

	typedef enum logic [1:0] {
		DS_DIE2,
		DS_DIE3,
		DS_SALT,
		DS_ZERO
	} dsel_t;

	typedef enum logic [1:0] {
		JC_NEXT,
		JC_LOOP,
		JC_MAC
	} jcond_t;

	typedef struct packed {
		op_t    op;
		dsel_t  dsel;
		jcond_t jcond;
		pc_t    target;
	} ucode_t;

	typedef struct packed {
		logic load;
		logic mix;
	} dp_ctrl_t;

endpackage

### rtl/dil_lfsr_dp.sv
// ----------------------------------------------------------------------------
// dil_lfsr_dp : galois lfsr hash datapath
// Loads the seed, then mixes one data bit per cycle while mix is set, lsb first, and shifts
// each output bit into a 64-bit result accumulator.
// ----------------------------------------------------------------------------
module dil_lfsr_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dil_pkg::dp_ctrl_t            ctrl,
	input  logic [dil_pkg::LFSR_W-1:0]   seed,
	input  logic [dil_pkg::WORD_W-1:0]   data_word,
	output logic [dil_pkg::LFSR_W-1:0]   acc,
	output logic                         word_last
);

	logic [dil_pkg::LFSR_W-1:0] lfsr_q;
	logic [dil_pkg::LFSR_W-1:0] acc_q;
	logic [dil_pkg::BIT_W-1:0]  bit_q;
	logic                       out_bit;
	logic                       fb;

	assign out_bit = lfsr_q[0];
	assign fb = out_bit ^ data_word[bit_q];
	assign word_last = (bit_q == dil_pkg::BIT_W'(dil_pkg::WORD_W - 1));
	assign acc = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (ctrl.load) begin
			bit_q <= '0;
		end else if (ctrl.mix) begin
			bit_q <= bit_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			lfsr_q <= seed;
			acc_q <= '0;
		end else if (ctrl.mix) begin
			lfsr_q <= (lfsr_q >> 1) ^ (fb ? dil_pkg::LFSR_TAPS : '0);
			acc_q <= {acc_q[dil_pkg::LFSR_W-2:0], out_bit};
		end
	end

endmodule

### rtl/dil_sequencer.sv
// ----------------------------------------------------------------------------
// dil_sequencer : microcode program counter and control rom
// One control word per step; mix steps last one word and then take their
// jump condition (next, blend loop, or skip the second word for a mac).
// ----------------------------------------------------------------------------
module dil_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                launch,
	input  logic                action,
	input  logic                word_last,
	output dil_pkg::dp_ctrl_t   ctrl,
	output dil_pkg::dsel_t      dsel,
	output logic                busy,
	output logic                emit
);

	dil_pkg::pc_t                 pc_q;
	dil_pkg::pc_t                 pc_n;
	dil_pkg::pc_t                 pc_inc;
	logic [dil_pkg::ROUND_W-1:0]  round_q;
	logic [dil_pkg::ROUND_W-1:0]  round_n;
	dil_pkg::ucode_t              ucw;

	// control rom
	always_comb begin
		ucw = '{op: dil_pkg::OP_IDLE, dsel: dil_pkg::DS_ZERO,
			jcond: dil_pkg::JC_NEXT, target: dil_pkg::ST_IDLE};
		case (pc_q)
			dil_pkg::ST_IDLE: begin
				ucw.op = dil_pkg::OP_IDLE;
			end
			dil_pkg::ST_LOAD: begin
				ucw.op = dil_pkg::OP_LOAD;
			end
			dil_pkg::ST_DIE2: begin
				ucw.op = dil_pkg::OP_MIX;
				ucw.dsel = dil_pkg::DS_DIE2;
			end
			dil_pkg::ST_DIE3: begin
				ucw.op = dil_pkg::OP_MIX;
				ucw.dsel = dil_pkg::DS_DIE3;
			end
			dil_pkg::ST_SALT: begin
				ucw.op = dil_pkg::OP_MIX;
				ucw.dsel = dil_pkg::DS_SALT;
			end
			dil_pkg::ST_BLEND: begin
				ucw.op = dil_pkg::OP_MIX;
				ucw.jcond = dil_pkg::JC_LOOP;
			end
			dil_pkg::ST_OUT0: begin
				ucw.op = dil_pkg::OP_MIX;
				ucw.jcond = dil_pkg::JC_MAC;
				ucw.target = dil_pkg::ST_EMIT;
			end
			dil_pkg::ST_OUT1: begin
				ucw.op = dil_pkg::OP_MIX;
			end
			dil_pkg::ST_EMIT: begin
				ucw.op = dil_pkg::OP_EMIT;
				ucw.target = dil_pkg::ST_IDLE;
			end
			default: begin
				ucw.op = dil_pkg::OP_EMIT;
				ucw.target = dil_pkg::ST_IDLE;
			end
		endcase
	end

	assign pc_inc = pc_q + 1'b1;

	always_comb begin
		pc_n = pc_q;
		round_n = round_q;
		case (ucw.op)
			dil_pkg::OP_IDLE: begin
				if (launch) begin
					pc_n = pc_inc;
				end
			end
			dil_pkg::OP_LOAD: begin
				pc_n = pc_inc;
			end
			dil_pkg::OP_MIX: begin
				if (word_last) begin
					case (ucw.jcond)
						dil_pkg::JC_LOOP: begin
							if (round_q == dil_pkg::ROUND_LAST) begin
								round_n = '0;
								pc_n = pc_inc;
							end else begin
								round_n = round_q + 1'b1;
							end
						end
						dil_pkg::JC_MAC: begin
							pc_n = (action == dil_pkg::ACT_MAC) ? ucw.target : pc_inc;
						end
						default: begin
							pc_n = pc_inc;
						end
					endcase
				end
			end
			dil_pkg::OP_EMIT: begin
				pc_n = ucw.target;
			end
			default: begin
				pc_n = dil_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= dil_pkg::ST_IDLE;
			round_q <= '0;
		end else begin
			pc_q <= pc_n;
			round_q <= round_n;
		end
	end

	assign ctrl.load = (ucw.op == dil_pkg::OP_LOAD);
	assign ctrl.mix = (ucw.op == dil_pkg::OP_MIX);
	assign dsel = ucw.dsel;
	assign busy = (pc_q != dil_pkg::ST_IDLE);
	assign emit = (ucw.op == dil_pkg::OP_EMIT);

	a_emit_returns: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (pc_q == dil_pkg::ST_IDLE))
		else $error("sequencer did not return to idle after emit");

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= dil_pkg::ST_EMIT)
		else $error("program counter beyond last step");

	a_round_in_loop: assert property (@(posedge clk) disable iff (!arst_n)
		(round_q != '0) |-> (pc_q == dil_pkg::ST_BLEND))
		else $error("blend round count live outside blend step");

	a_launch_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(launch && !busy) |=> ctrl.load)
		else $error("accepted request did not load the register");

endmodule

### rtl/die_id_lfsr_id_generator.sv
// ----------------------------------------------------------------------------
// die_id_lfsr_id_generator : default identifier from die id and salt
// Hashes the die id and a salt through a 64-bit galois lfsr and returns a
// mac address or a 64-bit identifier.
// ----------------------------------------------------------------------------
// usage:
//   configuration: write die_word0..3 through cfg_valid/cfg_ready with
//   cfg_index and cfg_data while the block is idle; cfg_ready is always high.
//   request: a beat is taken when start is high and busy is low, carrying
//   action (0 = mac, 1 = 64-bit id) and salt.
//   result: id_value is presented for one cycle with done high; there is no
//   back-pressure, the result must be taken in that cycle.
// sequence: one lfsr bit per cycle; 4 + BLEND_ROUNDS words of 32 bits for a
//   mac and one word more for an id, plus load and emit steps; the
//   single-bit lfsr step of the datapath sets the time to done; one request
//   at a time, a new start is taken in the cycle done is shown.
// reset: arst_n clears the die id registers to zero and returns the program
//   counter to idle; no result is pending after reset.
// ----------------------------------------------------------------------------
module die_id_lfsr_id_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          action,
	input  logic [dil_pkg::WORD_W-1:0]    salt,
	output logic                          done,
	output logic [dil_pkg::LFSR_W-1:0]    id_value,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [dil_pkg::WORD_W-1:0]    cfg_data
);

	logic [dil_pkg::WORD_W-1:0] die_word0_q;
	logic [dil_pkg::WORD_W-1:0] die_word1_q;
	logic [dil_pkg::WORD_W-1:0] die_word2_q;
	logic [dil_pkg::WORD_W-1:0] die_word3_q;
	logic                       action_q;
	logic [dil_pkg::WORD_W-1:0] salt_q;
	logic                       done_q;
	logic [dil_pkg::LFSR_W-1:0] id_value_q;
	logic                       launch;
	logic                       word_last;
	logic                       emit;
	dil_pkg::dp_ctrl_t          ctrl;
	dil_pkg::dsel_t             dsel;
	logic [dil_pkg::WORD_W-1:0] data_word;
	logic [dil_pkg::LFSR_W-1:0] acc;

	assign cfg_ready = 1'b1;
	assign launch = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			die_word0_q <= '0;
			die_word1_q <= '0;
			die_word2_q <= '0;
			die_word3_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dil_pkg::REG_DIE_WORD0: die_word0_q <= cfg_data;
				dil_pkg::REG_DIE_WORD1: die_word1_q <= cfg_data;
				dil_pkg::REG_DIE_WORD2: die_word2_q <= cfg_data;
				dil_pkg::REG_DIE_WORD3: die_word3_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			action_q <= action;
			salt_q <= salt;
		end
	end

	always_comb begin
		case (dsel)
			dil_pkg::DS_DIE2: data_word = die_word2_q;
			dil_pkg::DS_DIE3: data_word = die_word3_q;
			dil_pkg::DS_SALT: data_word = salt_q;
			default:          data_word = '0;
		endcase
	end

	dil_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.launch    (launch),
		.action    (action_q),
		.word_last (word_last),
		.ctrl      (ctrl),
		.dsel      (dsel),
		.busy      (busy),
		.emit      (emit)
	);

	dil_lfsr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.seed      ({die_word1_q, die_word0_q}),
		.data_word (data_word),
		.acc       (acc),
		.word_last (word_last)
	);

	// mac keeps only the low 24 output bits of the first word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (action_q == dil_pkg::ACT_MAC) begin
				id_value_q <= {16'h0000, acc[dil_pkg::MAC_RAND_W-1:0], dil_pkg::MAC_TAIL};
			end else begin
				id_value_q <= acc;
			end
		end
	end

	assign done = done_q;
	assign id_value = id_value_q;

endmodule
